@@ design/gbn_pkg.sv @@
// Package for the greedy box suppression block: payload structs, stored geometry
// format, sequencer states and sizing constants. No dependencies.

package gbn_pkg;

  localparam int MAX_BOXES = 64;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ONE_PIXEL = 16;
  localparam logic [15:0] THR_RESET = 16'd32768;

  typedef struct packed {
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic [15:0]        box_score;
    logic               set_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] kept_x;
    logic signed [15:0] kept_y;
    logic [14:0]        kept_width;
    logic [14:0]        kept_height;
    logic [15:0]        kept_score;
    logic               run_end;
    logic               overflowed;
  } out_beat_t;

  typedef struct packed {
    logic [14:0]        h;
    logic [14:0]        w;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } geom_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RK_RDI,
    S_RK_LDI,
    S_RK_CMP,
    S_NM_RDI,
    S_NM_CHKI,
    S_NM_LDA,
    S_NM_ARA,
    S_NM_RDJ,
    S_NM_CHKJ,
    S_NM_IWH,
    S_NM_INT,
    S_NM_ARB,
    S_NM_UNI,
    S_NM_THR,
    S_NM_DEC,
    S_CT,
    S_EM_RD,
    S_EM_CHK,
    S_EM_OUT
  } state_t;

endpackage

@@ design/greedy_box_nms.sv @@
// Greedy non-maximum suppression over one set of boxes, with rank sort and one
// shared 16x32 multiplier. Depends on gbn_pkg.
// A set is processed after its set_end beat: the boxes are ranked to sort them,
// the suppression pass checks box pairs (the multiplier is used three times per
// pair), the survivors are counted, and the kept boxes are emitted. busy stays
// high throughout, so one set is processed at a time. Reset (synchronous, rst_n
// low) empties the store and sets the threshold to one half; results cannot be
// stalled.

module greedy_box_nms
  import gbn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_data,
  output logic      out_valid,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [15:0] cfg_wdata
);

  // Box stores and the sort order. Store entries are only read for boxes
  // loaded in the current set, so they need no clearing.
  geom_t             geom_mem  [MAX_BOXES];
  logic [15:0]       score_mem [MAX_BOXES];
  logic [IDX_W-1:0]  order_mem [MAX_BOXES];

  geom_t             geom_q;
  logic [15:0]       score_q;
  logic [IDX_W-1:0]  order_q;

  logic              geom_re, score_re, order_re;
  logic [IDX_W-1:0]  geom_raddr, score_raddr, order_raddr;
  logic              order_we;
  logic [IDX_W-1:0]  order_waddr;
  logic              load_we;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_cnt_r, loaded_cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic [15:0]       thr_r;
  logic [MAX_BOXES-1:0] surv_r, surv_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic [CNT_W-1:0]  keep_cnt_r, keep_cnt_nxt, emit_cnt_r, emit_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  logic [15:0]       si_r, si_nxt;
  geom_t             ga_r, ga_nxt;
  logic [29:0]       area_a_r, area_a_nxt, area_b_r, area_b_nxt;
  logic [IDX_W-1:0]  b_r, b_nxt;
  logic [15:0]       iw_r, iw_nxt, ih_r, ih_nxt;
  logic [31:0]       inter_r, inter_nxt;
  logic signed [33:0] uni_r, uni_nxt;
  logic [47:0]       rhs_r, rhs_nxt;

  // Shared multiplier.
  logic [15:0]       mul_a;
  logic [31:0]       mul_b;
  logic [47:0]       mul_p;
  assign mul_p = {32'd0, mul_a} * {16'd0, mul_b};

  // Overlap extents between the held box A and the box just read.
  logic signed [18:0] a_l, a_t, a_r, a_b, b_l, b_t, b_rt, b_bt, dx, dy;
  always_comb begin
    a_l  = {{3{ga_r.x[15]}}, ga_r.x};
    a_t  = {{3{ga_r.y[15]}}, ga_r.y};
    b_l  = {{3{geom_q.x[15]}}, geom_q.x};
    b_t  = {{3{geom_q.y[15]}}, geom_q.y};
    a_r  = a_l + $signed({4'd0, ga_r.w});
    a_b  = a_t + $signed({4'd0, ga_r.h});
    b_rt = b_l + $signed({4'd0, geom_q.w});
    b_bt = b_t + $signed({4'd0, geom_q.h});
    dx   = ((a_r < b_rt) ? a_r : b_rt) - ((a_l > b_l) ? a_l : b_l) + 19'sd16;
    dy   = ((a_b < b_bt) ? a_b : b_bt) - ((a_t > b_t) ? a_t : b_t) + 19'sd16;
  end

  logic              rank_hit;
  assign rank_hit = (score_q > si_r) || ((score_q == si_r) && (j_r < i_r));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Memories.
  always_ff @(posedge clk) begin
    if (load_we) begin
      geom_mem[loaded_cnt_r[IDX_W-1:0]]  <= '{h: in_data.box_height, w: in_data.box_width,
                                             y: in_data.box_y, x: in_data.box_x};
      score_mem[loaded_cnt_r[IDX_W-1:0]] <= in_data.box_score;
    end
    if (order_we) begin
      order_mem[order_waddr] <= i_r[IDX_W-1:0];
    end
    if (geom_re) begin
      geom_q <= geom_mem[geom_raddr];
    end
    if (score_re) begin
      score_q <= score_mem[score_raddr];
    end
    if (order_re) begin
      order_q <= order_mem[order_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_cnt_r <= '0;
      ovf_r        <= 1'b0;
      thr_r        <= THR_RESET;
      surv_r       <= '1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      loaded_cnt_r <= loaded_cnt_nxt;
      ovf_r        <= ovf_nxt;
      surv_r       <= surv_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    keep_cnt_r <= keep_cnt_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    out_r      <= out_nxt;
    si_r       <= si_nxt;
    ga_r       <= ga_nxt;
    area_a_r   <= area_a_nxt;
    area_b_r   <= area_b_nxt;
    b_r        <= b_nxt;
    iw_r       <= iw_nxt;
    ih_r       <= ih_nxt;
    inter_r    <= inter_nxt;
    uni_r      <= uni_nxt;
    rhs_r      <= rhs_nxt;
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    loaded_cnt_nxt = loaded_cnt_r;
    ovf_nxt        = ovf_r;
    surv_nxt       = surv_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    rank_nxt       = rank_r;
    keep_cnt_nxt   = keep_cnt_r;
    emit_cnt_nxt   = emit_cnt_r;
    si_nxt         = si_r;
    ga_nxt         = ga_r;
    area_a_nxt     = area_a_r;
    area_b_nxt     = area_b_r;
    b_nxt          = b_r;
    iw_nxt         = iw_r;
    ih_nxt         = ih_r;
    inter_nxt      = inter_r;
    uni_nxt        = uni_r;
    rhs_nxt        = rhs_r;
    geom_re        = 1'b0;
    score_re       = 1'b0;
    order_re       = 1'b0;
    geom_raddr     = '0;
    score_raddr    = '0;
    order_raddr    = '0;
    order_we       = 1'b0;
    order_waddr    = '0;
    load_we        = 1'b0;
    mul_a          = '0;
    mul_b          = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (loaded_cnt_r < CNT_W'(MAX_BOXES)) begin
            load_we        = 1'b1;
            loaded_cnt_nxt = loaded_cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.set_end) begin
            i_nxt     = '0;
            state_nxt = S_RK_RDI;
          end
        end
      end

      // Rank of box i = boxes with higher score, or equal score loaded earlier.
      S_RK_RDI: begin
        score_re    = 1'b1;
        score_raddr = i_r[IDX_W-1:0];
        state_nxt   = S_RK_LDI;
      end
      S_RK_LDI: begin
        si_nxt      = score_q;
        j_nxt       = '0;
        rank_nxt    = '0;
        score_re    = 1'b1;
        score_raddr = '0;
        state_nxt   = S_RK_CMP;
      end
      S_RK_CMP: begin
        rank_nxt    = rank_r + CNT_W'(rank_hit);
        j_nxt       = j_r + 1'b1;
        score_re    = 1'b1;
        score_raddr = j_nxt[IDX_W-1:0];
        if (j_nxt == loaded_cnt_r) begin
          order_we    = 1'b1;
          order_waddr = rank_nxt[IDX_W-1:0];
          i_nxt       = i_r + 1'b1;
          state_nxt   = (i_nxt == loaded_cnt_r) ? S_NM_RDI : S_RK_RDI;
          if (i_nxt == loaded_cnt_r) begin
            i_nxt = '0;
          end
        end
      end

      // Suppression pass, outer box A in sorted order.
      S_NM_RDI: begin
        order_re    = 1'b1;
        order_raddr = i_r[IDX_W-1:0];
        state_nxt   = S_NM_CHKI;
      end
      S_NM_CHKI: begin
        if (i_r + 1'b1 >= loaded_cnt_r) begin
          i_nxt     = '0;
          keep_cnt_nxt = '0;
          state_nxt = S_CT;
        end else if (surv_r[order_q]) begin
          geom_re    = 1'b1;
          geom_raddr = order_q;
          state_nxt  = S_NM_LDA;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_NM_RDI;
        end
      end
      S_NM_LDA: begin
        ga_nxt    = geom_q;
        j_nxt     = i_r + 1'b1;
        state_nxt = S_NM_ARA;
      end
      S_NM_ARA: begin
        mul_a      = {1'b0, ga_r.w};
        mul_b      = {17'd0, ga_r.h};
        area_a_nxt = mul_p[29:0];
        state_nxt  = S_NM_RDJ;
      end
      S_NM_RDJ: begin
        order_re    = 1'b1;
        order_raddr = j_r[IDX_W-1:0];
        state_nxt   = S_NM_CHKJ;
      end
      S_NM_CHKJ: begin
        b_nxt = order_q;
        if (surv_r[order_q]) begin
          geom_re    = 1'b1;
          geom_raddr = order_q;
          state_nxt  = S_NM_IWH;
        end else begin
          j_nxt = j_r + 1'b1;
          if (j_nxt == loaded_cnt_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_NM_RDI;
          end else begin
            state_nxt = S_NM_RDJ;
          end
        end
      end
      S_NM_IWH: begin
        iw_nxt    = dx[18] ? 16'd0 : dx[15:0];
        ih_nxt    = dy[18] ? 16'd0 : dy[15:0];
        state_nxt = S_NM_INT;
      end
      S_NM_INT: begin
        mul_a     = iw_r;
        mul_b     = {16'd0, ih_r};
        inter_nxt = mul_p[31:0];
        state_nxt = S_NM_ARB;
      end
      S_NM_ARB: begin
        mul_a      = {1'b0, geom_q.w};
        mul_b      = {17'd0, geom_q.h};
        area_b_nxt = mul_p[29:0];
        state_nxt  = S_NM_UNI;
      end
      S_NM_UNI: begin
        uni_nxt   = $signed({4'd0, area_a_r}) + $signed({4'd0, area_b_r})
                    - $signed({2'd0, inter_r});
        state_nxt = S_NM_THR;
      end
      S_NM_THR: begin
        mul_a     = thr_r;
        mul_b     = uni_r[31:0];
        rhs_nxt   = mul_p;
        state_nxt = S_NM_DEC;
      end
      S_NM_DEC: begin
        // A negative union keeps the box; a zero union drops it when overlapping.
        if (!uni_r[33] && ({inter_r, 16'd0} > rhs_r)) begin
          surv_nxt[b_r] = 1'b0;
        end
        j_nxt = j_r + 1'b1;
        if (j_nxt == loaded_cnt_r) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_NM_RDI;
        end else begin
          state_nxt = S_NM_RDJ;
        end
      end

      // Count survivors so the last beat can be marked.
      S_CT: begin
        keep_cnt_nxt = keep_cnt_r + CNT_W'(surv_r[i_r[IDX_W-1:0]]);
        i_nxt        = i_r + 1'b1;
        if (i_nxt == loaded_cnt_r) begin
          i_nxt        = '0;
          emit_cnt_nxt = '0;
          state_nxt    = S_EM_RD;
        end
      end

      S_EM_RD: begin
        order_re    = 1'b1;
        order_raddr = i_r[IDX_W-1:0];
        state_nxt   = S_EM_CHK;
      end
      S_EM_CHK: begin
        if (surv_r[order_q]) begin
          geom_re     = 1'b1;
          score_re    = 1'b1;
          geom_raddr  = order_q;
          score_raddr = order_q;
          state_nxt   = S_EM_OUT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_nxt == loaded_cnt_r) ? S_IDLE : S_EM_RD;
        end
        if (!surv_r[order_q] && (i_nxt == loaded_cnt_r)) begin
          loaded_cnt_nxt = '0;
          ovf_nxt        = 1'b0;
          surv_nxt       = '1;
        end
      end
      S_EM_OUT: begin
        out_valid_nxt       = 1'b1;
        out_nxt.kept_x      = geom_q.x;
        out_nxt.kept_y      = geom_q.y;
        out_nxt.kept_width  = geom_q.w;
        out_nxt.kept_height = geom_q.h;
        out_nxt.kept_score  = score_q;
        out_nxt.run_end     = (emit_cnt_r + 1'b1 == keep_cnt_r);
        out_nxt.overflowed  = ovf_r;
        emit_cnt_nxt        = emit_cnt_r + 1'b1;
        i_nxt               = i_r + 1'b1;
        if (i_nxt == loaded_cnt_r) begin
          loaded_cnt_nxt = '0;
          ovf_nxt        = 1'b0;
          surv_nxt       = '1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= CNT_W'(MAX_BOXES))
    else $error("loaded box count beyond capacity");

  a_set_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.set_end |=> busy)
    else $error("set end beat did not start processing");

  a_beat_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beats closer than expected");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |-> busy)
    else $error("non-final result beat while idle");

endmodule

@@ tb/sv/greedy_box_nms_test.sv @@
// Self-checking testbench for greedy_box_nms: loads sets of boxes, predicts the
// kept boxes with an in-bench suppression model and compares every result beat.
// Depends on gbn_pkg and greedy_box_nms.

module greedy_box_nms_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_data;
  logic      out_valid;
  out_beat_t out_data;
  logic      cfg_we;
  logic [15:0] cfg_wdata;

  greedy_box_nms dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the boxes of the set being loaded, overflow and threshold.
  in_beat_t    held_boxes[$];
  bit          spill_seen;
  logic [15:0] overlap_thr;
  out_beat_t   kept_queue[$];
  int          error_count;
  int          no_gap_lo, no_gap_hi;
  int          beat_index;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Overlap test. The one-pixel bonus (16 in Q12.4) widens the intersection.
  function automatic bit drops_lower(in_beat_t a, in_beat_t b);
    longint ax, ay, aw, ah, bx, by, bw, bh, iw, ih, inter, uni, lo, hi;
    ax = longint'(a.box_x); ay = longint'(a.box_y);
    aw = longint'(a.box_width); ah = longint'(a.box_height);
    bx = longint'(b.box_x); by = longint'(b.box_y);
    bw = longint'(b.box_width); bh = longint'(b.box_height);
    hi = (ax + aw < bx + bw) ? ax + aw : bx + bw;
    lo = (ax > bx) ? ax : bx;
    iw = hi - lo + ONE_PIXEL;
    if (iw < 0) iw = 0;
    hi = (ay + ah < by + bh) ? ay + ah : by + bh;
    lo = (ay > by) ? ay : by;
    ih = hi - lo + ONE_PIXEL;
    if (ih < 0) ih = 0;
    inter = iw * ih;
    uni = aw * ah + bw * bh - inter;
    // A negative union keeps the box; a zero union drops it on any overlap.
    if (uni < 0) return 1'b0;
    return inter * 65536 > longint'(overlap_thr) * uni;
  endfunction

  // Accepts one box into the predictor and, on set_end, queues the survivors.
  task automatic predict_box(in_beat_t b);
    int order[$];
    bit alive[$];
    int k, last;
    out_beat_t r;
    if (held_boxes.size() < MAX_BOXES) held_boxes.insert(held_boxes.size(), b);
    else spill_seen = 1'b1;
    if (!b.set_end) return;
    // Stable sort by descending score.
    for (int i = 0; i < held_boxes.size(); i++) begin
      k = 0;
      while (k < order.size() && held_boxes[order[k]].box_score >= held_boxes[i].box_score)
        k++;
      order.insert(k, i);
      alive.insert(alive.size(), 1'b1);
    end
    for (int i = 0; i < order.size(); i++) begin
      if (!alive[order[i]]) continue;
      for (int j = i + 1; j < order.size(); j++)
        if (alive[order[j]] && drops_lower(held_boxes[order[i]], held_boxes[order[j]]))
          alive[order[j]] = 1'b0;
    end
    last = -1;
    for (int i = 0; i < order.size(); i++) if (alive[order[i]]) last = i;
    for (int i = 0; i < order.size(); i++) begin
      if (!alive[order[i]]) continue;
      r.kept_x      = held_boxes[order[i]].box_x;
      r.kept_y      = held_boxes[order[i]].box_y;
      r.kept_width  = held_boxes[order[i]].box_width;
      r.kept_height = held_boxes[order[i]].box_height;
      r.kept_score  = held_boxes[order[i]].box_score;
      r.run_end     = (i == last);
      r.overflowed  = spill_seen;
      kept_queue.insert(kept_queue.size(), r);
    end
    held_boxes.delete();
    spill_seen = 1'b0;
  endtask

  // Result checker: every strobed beat is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (kept_queue.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data);
        error_count++;
      end else begin
        if (out_data !== kept_queue[0]) begin
          $display("%0t: expected %p, actual %p", $time, kept_queue[0], out_data);
          error_count++;
        end
        void'(kept_queue.pop_front());
      end
    end
  end

  // Drives one box: hold start until an edge with busy low, then predict.
  // start stays high on return; an idle gap or the caller lowers it.
  task automatic send_box(in_beat_t b);
    beat_index++;
    if (!(beat_index >= no_gap_lo && beat_index < no_gap_hi))
      while ($urandom_range(99) < 32) begin
        start <= 1'b0;
        @(negedge clk);
      end
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_box(b);
    @(negedge clk);
  endtask

  // Threshold write between sets, once every expected beat has come and the
  // sequencer has settled back to idle.
  task automatic write_threshold(logic [15:0] v);
    start <= 1'b0;
    while (kept_queue.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    overlap_thr = v;
  endtask

  function automatic in_beat_t mk_box(int x, int y, int w, int h, int s, bit e);
    in_beat_t b;
    b.box_x = 16'(x); b.box_y = 16'(y); b.box_width = 15'(w); b.box_height = 15'(h);
    b.box_score = 16'(s); b.set_end = e;
    return b;
  endfunction

  function automatic in_beat_t rand_box(bit e, bit spread);
    in_beat_t b;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    b = raw[$bits(in_beat_t)-1:0];
    if (!spread) begin
      // Clustered boxes so that overlaps and suppression happen often.
      b.box_x = 16'($urandom_range(0, 800) - 400);
      b.box_y = 16'($urandom_range(0, 800) - 400);
      b.box_width  = 15'($urandom_range(0, 600));
      b.box_height = 15'($urandom_range(0, 600));
      if ($urandom_range(3) == 0) b.box_score = 16'($urandom_range(3));
    end
    b.set_end = e;
    return b;
  endfunction

  // Directed table: the expected result is typed in where it is obvious.
  typedef struct {
    in_beat_t  box;
    bit        has_expect;
    out_beat_t expect_beat;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(in_beat_t b);
    dir_row_t r;
    r.box = b;
    r.has_expect = 1'b0;
    r.expect_beat = '0;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  initial begin
    int n, set_len, sets_done;
    bit spread;
    error_count = 0;
    beat_index = 0;
    no_gap_lo = 60;
    no_gap_hi = 110;
    spill_seen = 1'b0;
    overlap_thr = THR_RESET;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single extreme box: it survives alone and is its own run end.
    begin
      dir_row_t r;
      r.box = mk_box(-32768, 32767, 32767, 32767, 65535, 1);
      r.has_expect = 1'b1;
      r.expect_beat = '{kept_x: 16'h8000, kept_y: 16'h7FFF, kept_width: 15'h7FFF,
                        kept_height: 15'h7FFF, kept_score: 16'hFFFF, run_end: 1'b1,
                        overflowed: 1'b0};
      dir_rows.insert(dir_rows.size(), r);
    end
    // Identical boxes with a score tie: load order wins, the second is dropped.
    add_row(mk_box(0, 0, 160, 160, 100, 0));
    add_row(mk_box(0, 0, 160, 160, 100, 1));
    // Zero-sized boxes at the same spot: negative union with positive overlap.
    add_row(mk_box(5, 5, 0, 0, 0, 0));
    add_row(mk_box(5, 5, 0, 0, 7, 1));
    // Disjoint boxes and an identical pair with huge extents.
    add_row(mk_box(32767, -32768, 0, 32767, 65535, 0));
    add_row(mk_box(-32768, -32768, 32767, 32767, 1, 0));
    add_row(mk_box(-32768, -32768, 32767, 32767, 2, 0));
    add_row(mk_box(1000, 1000, 16, 16, 300, 1));
    // Partial overlap at the default threshold.
    add_row(mk_box(0, 0, 320, 320, 500, 0));
    add_row(mk_box(160, 0, 320, 320, 600, 0));
    add_row(mk_box(80, 80, 320, 320, 400, 1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_expect) begin
        send_box(dir_rows[i].box);
        // The typed-in beat replaces the predicted one for this row.
        kept_queue[kept_queue.size() - 1] = dir_rows[i].expect_beat;
      end else begin
        send_box(dir_rows[i].box);
      end
    end

    // Threshold extremes: zero drops any positive overlap, all ones almost none.
    write_threshold(16'h0000);
    send_box(mk_box(0, 0, 160, 160, 10, 0));
    send_box(mk_box(150, 150, 160, 160, 20, 1));
    write_threshold(16'hFFFF);
    send_box(mk_box(0, 0, 160, 160, 10, 0));
    send_box(mk_box(8, 8, 160, 160, 20, 0));
    send_box(mk_box(0, 0, 160, 160, 30, 1));

    // Overflow: one full store plus spilled boxes, the last spill ends the set.
    write_threshold(16'd20000);
    for (int i = 0; i < MAX_BOXES + 2; i++)
      send_box(rand_box(i == MAX_BOXES + 1, 1'b0));

    // Random sets, mostly small and clustered, across several thresholds.
    sets_done = 0;
    n = 0;
    while (n < 100) begin
      if (sets_done % 6 == 0) begin
        case ($urandom_range(3))
          0: write_threshold(16'h0000);
          1: write_threshold(16'hFFFF);
          default: write_threshold(16'($urandom));
        endcase
      end
      set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      spread = ($urandom_range(4) == 0);
      for (int i = 0; i < set_len; i++) begin
        send_box(rand_box(i == set_len - 1, spread));
        n++;
      end
      sets_done++;
    end

    start <= 1'b0;
    while (kept_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
